FILE: hw/rtl/prl_pkg.sv
package prl_pkg;

  localparam int STAMP_W = 32;

  // Configuration register indexes
  localparam logic CFG_GLOBAL_MODE = 1'b0;
  localparam logic CFG_FRAME_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0]  proc_id;
    logic [15:0] page_num;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [9:0]  frame_num;
    logic [15:0] fault_count;
    logic        evicted_valid;
    logic [7:0]  evicted_proc;
    logic [15:0] evicted_page;
    logic        table_full;
  } rsp_t;

  typedef struct packed {
    logic [7:0]         owner;
    logic [15:0]        page;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // sequencer -> scan unit
  typedef struct packed {
    logic clr;
    logic vld;
    logic gmode;
  } scan_ctrl_t;

  // scan unit -> sequencer
  typedef struct packed {
    logic        found;
    logic        vic;
    logic [7:0]  vic_owner;
    logic [15:0] vic_page;
  } scan_stat_t;

endpackage

FILE: hw/rtl/prl_if.sv
interface prl_req_if;
  import prl_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prl_rsp_if;
  import prl_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/prl_ram.sv
module prl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/prl_scan.sv
// Shared match / age compare unit; one entry per cycle, data in the cycle after its address.
module prl_scan #(
  parameter int IDX_W = 10
) (
  input  logic                             clk,
  input  prl_pkg::scan_ctrl_t              ctrl,
  input  logic [IDX_W-1:0]                 idx,
  input  logic [7:0]                       pid,
  input  logic [15:0]                      page,
  input  logic [prl_pkg::STAMP_W-1:0]      stamp_now,
  input  prl_pkg::entry_t                  rdata,
  output prl_pkg::scan_stat_t              stat,
  output logic [IDX_W-1:0]                 found_idx,
  output logic [IDX_W-1:0]                 vic_idx
);
  import prl_pkg::*;

  logic               vld_r;
  logic [IDX_W-1:0]   idx_r;
  logic               found_r, vic_r;
  logic [IDX_W-1:0]   fidx_r, vidx_r;
  logic [7:0]         vown_r;
  logic [15:0]        vpage_r;
  logic [STAMP_W-1:0] best_r;
  logic [STAMP_W-1:0] age;
  logic               own;

  assign age = stamp_now - rdata.stamp;
  assign own = (rdata.owner == pid);

  always_ff @(posedge clk) begin
    vld_r <= ctrl.vld & ~ctrl.clr;
    idx_r <= idx;
    if (ctrl.clr) begin
      found_r <= 1'b0;
      vic_r   <= 1'b0;
    end else if (vld_r) begin
      if (own && rdata.page == page && !found_r) begin
        found_r <= 1'b1;
        fidx_r  <= idx_r;
      end
      if ((ctrl.gmode || own) && (!vic_r || age > best_r)) begin
        vic_r   <= 1'b1;
        vidx_r  <= idx_r;
        best_r  <= age;
        vown_r  <= rdata.owner;
        vpage_r <= rdata.page;
      end
    end
  end

  assign stat.found     = found_r;
  assign stat.vic       = vic_r;
  assign stat.vic_owner = vown_r;
  assign stat.vic_page  = vpage_r;
  assign found_idx      = fidx_r;
  assign vic_idx        = vidx_r;

endmodule

FILE: hw/rtl/page_replacement_lru_fifo_unit.sv
// Page replacement unit: per-process LRU sets or one shared FIFO set.
// in_ch carries one memory reference word (proc_id, page_num); out_ch returns
// one result word per reference: hit, frame, fault total, eviction, table_full.
// cfg_we/cfg_idx/cfg_data write global_mode (index 0) and frame_limit (index 1);
// the user must write them only while the unit is idle, which the unit itself
// does not enforce. A global_mode change flushes all resident pages.
// Each reference walks the process table (S_PSCAN), resolves the process
// (S_PRES), walks the entry store one entry a cycle through the registered
// RAM port (S_ESCAN, S_DRAIN), then decides and writes (S_DEC) and loads the
// output register (S_DONE). With no frame in use the entry walk is skipped;
// with the process table full, the entry walk and the decide step are skipped.
// in_ch is ready only in S_IDLE, so one reference is in work at a time.
// A finished result sits in the output register; a new reference is accepted
// meanwhile, but its result waits until out_ch takes the previous one.
// Reset (synchronous, rst_n low) empties the process table and entry store
// (fill count to zero), clears the stamp counter and sets mode 0, limit 3.
module page_replacement_lru_fifo_unit #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  prl_req_if.sink     in_ch,
  prl_rsp_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [6:0]  cfg_data
);
  import prl_pkg::*;

  localparam int DEPTH = MAX_PROCS * MAX_FRAMES;
  localparam int EIW   = $clog2(DEPTH);
  localparam int NFW   = $clog2(DEPTH + 1);
  localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW    = (NFW > 9) ? NFW : 9;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PSCAN = 3'd1;
  localparam logic [2:0] S_PRES  = 3'd2;
  localparam logic [2:0] S_ESCAN = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic       gmode_r;
  logic [6:0] limit_r;

  // process table
  logic        pvalid_r [MAX_PROCS];
  logic [7:0]  pident_r [MAX_PROCS];
  logic [15:0] pfaults_r [MAX_PROCS];
  logic [6:0]  pres_r [MAX_PROCS];

  // current reference
  req_t        req_r;
  logic [PIW-1:0] pcnt_r, p_r, free_r;
  logic        pfound_r, ffound_r;
  logic [15:0] cur_faults_r;
  logic [6:0]  cur_res_r;

  logic [EIW-1:0]     ecnt_r;
  logic [NFW-1:0]     next_frame_r;
  logic [STAMP_W-1:0] stamp_r;

  rsp_t res_r;
  rsp_t out_r;
  logic out_valid_r;

  // entry store
  logic           ram_we;
  logic [EIW-1:0] ram_waddr;
  entry_t         ram_wdata, ram_rdata;

  scan_ctrl_t     sctrl;
  scan_stat_t     sstat;
  logic [EIW-1:0] found_idx, vic_idx;

  // effective limit: 0 acts as 1, clamp to MAX_FRAMES
  logic [CW-1:0] lim;
  logic [CW-1:0] nf_w;
  logic          room;
  logic          out_free;

  always_comb begin
    lim = CW'(limit_r);
    if (limit_r == 7'd0) begin
      lim = CW'(1);
    end
    if (lim > CW'(MAX_FRAMES)) begin
      lim = CW'(MAX_FRAMES);
    end
  end

  assign nf_w     = CW'(next_frame_r);
  assign room     = (gmode_r ? (nf_w < lim) : (CW'(cur_res_r) < lim)) &&
                    (next_frame_r < NFW'(DEPTH));
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign sctrl.clr   = (state_r == S_PRES);
  assign sctrl.vld   = (state_r == S_ESCAN);
  assign sctrl.gmode = gmode_r;

  prl_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ecnt_r),
    .rdata (ram_rdata)
  );

  prl_scan #(.IDX_W(EIW)) u_scan (
    .clk       (clk),
    .ctrl      (sctrl),
    .idx       (ecnt_r),
    .pid       (req_r.proc_id),
    .page      (req_r.page_num),
    .stamp_now (stamp_r),
    .rdata     (ram_rdata),
    .stat      (sstat),
    .found_idx (found_idx),
    .vic_idx   (vic_idx)
  );

  // entry write in the decide step: refresh (local mode only), fill or replace
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = found_idx;
    ram_wdata.owner = req_r.proc_id;
    ram_wdata.page  = req_r.page_num;
    ram_wdata.stamp = stamp_r;
    if (state_r == S_DEC) begin
      if (sstat.found) begin
        ram_we = !gmode_r;
      end else if (room) begin
        ram_we    = 1'b1;
        ram_waddr = EIW'(next_frame_r);
      end else if (sstat.vic) begin
        ram_we    = 1'b1;
        ram_waddr = vic_idx;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_PSCAN;
      S_PSCAN: if (pcnt_r == PIW'(MAX_PROCS - 1)) state_nxt = S_PRES;
      S_PRES: begin
        if (!pfound_r && !ffound_r) state_nxt = S_DONE;
        else if (next_frame_r == '0) state_nxt = S_DEC;
        else state_nxt = S_ESCAN;
      end
      S_ESCAN: if (NFW'(ecnt_r) + NFW'(1) == next_frame_r) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DEC;
      S_DEC:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gmode_r      <= 1'b0;
      limit_r      <= 7'd3;
      next_frame_r <= '0;
      stamp_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        pvalid_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;

      // output register: load when free, else drop once taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_idx)
          CFG_GLOBAL_MODE: begin
            if (cfg_data[0] != gmode_r) begin
              next_frame_r <= '0;
              for (int i = 0; i < MAX_PROCS; i++) begin
                pres_r[i] <= 7'd0;
              end
            end
            gmode_r <= cfg_data[0];
          end
          CFG_FRAME_LIMIT: limit_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          req_r    <= in_ch.data;
          pcnt_r   <= '0;
          pfound_r <= 1'b0;
          ffound_r <= 1'b0;
        end
        S_PSCAN: begin
          pcnt_r <= pcnt_r + PIW'(1);
          if (pvalid_r[pcnt_r] && pident_r[pcnt_r] == req_r.proc_id && !pfound_r) begin
            pfound_r     <= 1'b1;
            p_r          <= pcnt_r;
            cur_faults_r <= pfaults_r[pcnt_r];
            cur_res_r    <= pres_r[pcnt_r];
          end
          if (!pvalid_r[pcnt_r] && !ffound_r) begin
            ffound_r <= 1'b1;
            free_r   <= pcnt_r;
          end
        end
        S_PRES: begin
          ecnt_r <= '0;
          if (!pfound_r && !ffound_r) begin
            res_r <= '{table_full: 1'b1, default: '0};
          end else begin
            res_r <= '0;
          end
          if (!pfound_r && ffound_r) begin
            // new process takes the first free slot
            p_r              <= free_r;
            pvalid_r[free_r] <= 1'b1;
            pident_r[free_r] <= req_r.proc_id;
            cur_faults_r     <= 16'd0;
            cur_res_r        <= 7'd0;
          end
        end
        S_ESCAN: ecnt_r <= ecnt_r + EIW'(1);
        S_DEC: begin
          stamp_r <= stamp_r + STAMP_W'(1);
          if (sstat.found) begin
            res_r.hit       <= 1'b1;
            res_r.frame_num <= 10'(found_idx);
            res_r.fault_count <= cur_faults_r;
            pfaults_r[p_r]  <= cur_faults_r;
            pres_r[p_r]     <= cur_res_r;
          end else begin
            res_r.fault_count <= (cur_faults_r == 16'hFFFF) ? cur_faults_r
                                                             : cur_faults_r + 16'd1;
            pfaults_r[p_r] <= (cur_faults_r == 16'hFFFF) ? cur_faults_r
                                                          : cur_faults_r + 16'd1;
            pres_r[p_r] <= (room && !gmode_r) ? cur_res_r + 7'd1 : cur_res_r;
            if (room) begin
              res_r.frame_num <= 10'(next_frame_r);
              next_frame_r    <= next_frame_r + NFW'(1);
            end else if (sstat.vic) begin
              res_r.frame_num     <= 10'(vic_idx);
              res_r.evicted_valid <= 1'b1;
              res_r.evicted_proc  <= sstat.vic_owner;
              res_r.evicted_page  <= sstat.vic_page;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_r <= res_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: bench/prl_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces are taken from the RTL (prl_req_if, prl_rsp_if); this file
// only holds the word-level helper types used by the bench.
package prl_tb_pkg;
  import prl_pkg::*;

  typedef struct {
    logic [7:0]  pid;
    logic [15:0] page;
    bit          has_gold;
    rsp_t        gold;
  } ref_row_t;
endpackage

FILE: bench/page_replacement_lru_fifo_unit_tb.sv
`timescale 1ns / 1ps
module page_replacement_lru_fifo_unit_tb;
  import prl_pkg::*;
  import prl_tb_pkg::*;

  localparam int NPROC   = 16;
  localparam int NFRAME  = 64;
  localparam int NENTRY  = NPROC * NFRAME;
  localparam int WDOG    = 200000;
  localparam int SETTLE  = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [6:0] cfg_data = '0;

  prl_req_if in_ch ();
  prl_rsp_if out_ch ();

  page_replacement_lru_fifo_unit #(.MAX_PROCS(NPROC), .MAX_FRAMES(NFRAME)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- shadow page tables ----------------
  bit          sh_gmode;
  logic [6:0]  sh_limit;
  bit          pt_valid [NPROC];
  logic [7:0]  pt_ident [NPROC];
  logic [15:0] pt_faults [NPROC];
  int unsigned pt_resident [NPROC];
  bit          fr_valid [NENTRY];
  logic [7:0]  fr_owner [NENTRY];
  logic [15:0] fr_page [NENTRY];
  logic [31:0] fr_stamp [NENTRY];
  logic [31:0] ref_clock;
  int unsigned frames_used;

  rsp_t expected_rsp[$];
  int   n_errors = 0;
  int   n_words_out = 0;
  int   n_hits = 0, n_evicts = 0, n_full = 0;

  // sender / receiver idle odds, percent
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  task automatic flush_frames();
    for (int i = 0; i < NENTRY; i++) fr_valid[i] = 1'b0;
    for (int i = 0; i < NPROC; i++) pt_resident[i] = 0;
    frames_used = 0;
  endtask

  task automatic shadow_reset();
    sh_gmode = 1'b0;
    sh_limit = 7'd3;
    for (int i = 0; i < NPROC; i++) begin
      pt_valid[i] = 1'b0;
      pt_faults[i] = '0;
    end
    flush_frames();
    ref_clock = '0;
  endtask

  // Resolve one reference against the shadow tables; returns the result word.
  function automatic rsp_t resolve_reference(logic [7:0] pid, logic [15:0] page);
    rsp_t r;
    int unsigned lim;
    int p, freep, found, victim;
    logic [31:0] best_age, age;
    logic [9:0] frame;
    bit room;
    r = '0;
    p = -1; freep = -1; found = -1; victim = -1; best_age = '0;
    lim = (sh_limit == 0) ? 1 : ((sh_limit > NFRAME) ? NFRAME : sh_limit);
    for (int i = 0; i < NPROC; i++) begin
      if (pt_valid[i] && pt_ident[i] == pid && p < 0) p = i;
      if (!pt_valid[i] && freep < 0) freep = i;
    end
    if (p < 0) begin
      if (freep < 0) begin
        r.table_full = 1'b1;
        return r;
      end
      p = freep;
      pt_valid[p] = 1'b1;
      pt_ident[p] = pid;
      pt_faults[p] = '0;
      pt_resident[p] = 0;
    end
    for (int i = 0; i < NENTRY; i++) begin
      if (!fr_valid[i]) continue;
      if (fr_owner[i] == pid && fr_page[i] == page && found < 0) found = i;
      if (sh_gmode || fr_owner[i] == pid) begin
        age = ref_clock - fr_stamp[i];
        if (victim < 0 || age > best_age) begin
          victim = i;
          best_age = age;
        end
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      frame = found[9:0];
      if (!sh_gmode) fr_stamp[found] = ref_clock;
    end else begin
      room = sh_gmode ? (frames_used < lim) : (pt_resident[p] < lim);
      if (room && frames_used < NENTRY) begin
        fr_valid[frames_used] = 1'b1;
        fr_owner[frames_used] = pid;
        fr_page[frames_used] = page;
        fr_stamp[frames_used] = ref_clock;
        frame = frames_used[9:0];
        frames_used++;
        if (!sh_gmode) pt_resident[p]++;
      end else if (victim >= 0) begin
        r.evicted_valid = 1'b1;
        r.evicted_proc = fr_owner[victim];
        r.evicted_page = fr_page[victim];
        fr_owner[victim] = pid;
        fr_page[victim] = page;
        fr_stamp[victim] = ref_clock;
        frame = victim[9:0];
      end else begin
        frame = '0;
      end
      if (pt_faults[p] != 16'hFFFF) pt_faults[p]++;
    end
    ref_clock++;
    r.frame_num = frame;
    r.fault_count = pt_faults[p];
    return r;
  endfunction

  // ---------------- config writes, only while idle ----------------
  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GLOBAL_MODE) begin
      if (val[0] != sh_gmode) flush_frames();
      sh_gmode = val[0];
    end else begin
      sh_limit = val;
    end
  endtask

  // drop valid, wait for the queue to drain, then let a stray in-flight word settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------- sender ----------------
  // Valid stays up after the accepting edge only when the next word follows
  // at once; idling and drain() lower it.
  task automatic send_word(logic [7:0] pid, logic [15:0] page);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.proc_id <= pid;
    in_ch.data.page_num <= page;
    expected_rsp.push_back(resolve_reference(pid, page));
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // ---------------- receiver + checker ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rsp_t got, want;
        got = out_ch.data;
        n_words_out++;
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result word %p", $realtime, got);
          n_errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            n_errors++;
          end
          if (want.hit) n_hits++;
          if (want.evicted_valid) n_evicts++;
          if (want.table_full) n_full++;
        end
      end
      out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: cycles with no handshake on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("watchdog: no progress for %0d cycles", WDOG);
      $display("** page_replacement_lru_fifo_unit: FAILED **");
      $finish;
    end
  end

  // ---------------- directed table ----------------
  ref_row_t rows[$];

  task automatic add_row(logic [7:0] pid, logic [15:0] page, bit g = 0, rsp_t gold = '0);
    ref_row_t r;
    r.pid = pid; r.page = page; r.has_gold = g; r.gold = gold;
    rows.push_back(r);
  endtask

  // random reference drawn from a small working set so hits and evictions occur;
  // ids start at 0x10, the processes registered by the table fill
  task automatic random_refs(int n, int nprocs);
    logic [7:0] pid;
    logic [15:0] page;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        pid = 8'($urandom);
        page = 16'($urandom);
      end else begin
        pid = 8'($urandom_range(nprocs - 1) + 16);
        page = 16'($urandom_range(7)) | (($urandom_range(3) == 0) ? 16'hFFF8 : 16'h0);
      end
      send_word(pid, page);
    end
  endtask

  initial begin
    rsp_t g;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    shadow_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of fields, hit, LRU eviction at reset limit 3.
    g = '0; g.frame_num = 10'd0; g.fault_count = 16'd1;
    add_row(8'h00, 16'h0000, 1, g);          // first fault after reset
    g = '0; g.hit = 1'b1; g.frame_num = 10'd0; g.fault_count = 16'd1;
    add_row(8'h00, 16'h0000, 1, g);          // hit on it
    add_row(8'hFF, 16'hFFFF);
    add_row(8'h00, 16'h0001);
    add_row(8'h00, 16'h0002);
    add_row(8'h00, 16'h0000);                // refresh recency
    add_row(8'h00, 16'h0003);                // evicts LRU page
    add_row(8'hFF, 16'hFFFF);
    add_row(8'h55, 16'hAAAA);
    add_row(8'hAA, 16'h5555);
    foreach (rows[i]) begin
      send_word(rows[i].pid, rows[i].page);
      if (rows[i].has_gold && expected_rsp[$] !== rows[i].gold) begin
        $display("%0t: table row %0d expected %p actual %p", $realtime, i,
                 rows[i].gold, expected_rsp[$]);
        n_errors++;
      end
    end
    drain();

    // Fill the process table, then one more unknown process: table full.
    for (int i = 0; i < NPROC; i++) send_word(8'(i + 16), 16'(i));
    g = '0; g.table_full = 1'b1;
    send_word(8'hEE, 16'h1234);
    if (expected_rsp[$] !== g) begin
      $display("%0t: table-full expected %p actual %p", $realtime, g, expected_rsp[$]);
      n_errors++;
    end
    drain();                                 // sender held until all results came
    write_reg(CFG_GLOBAL_MODE, 7'd1);        // flush, shared FIFO
    write_reg(CFG_FRAME_LIMIT, 7'd0);        // acts as 1
    send_word(8'h10, 16'h0);
    send_word(8'h11, 16'h1);
    send_word(8'h11, 16'h1);
    drain();

    // Random phases across modes, limits and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_GLOBAL_MODE, 7'(ph & 1));
      case (ph)
        0: write_reg(CFG_FRAME_LIMIT, 7'd1);
        1: write_reg(CFG_FRAME_LIMIT, 7'd64);
        2: write_reg(CFG_FRAME_LIMIT, 7'd127);
        3: write_reg(CFG_FRAME_LIMIT, 7'd2);
        default: write_reg(CFG_FRAME_LIMIT, 7'($urandom_range(1, 8)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      random_refs(70, (ph < 4) ? 4 : 14);
      if (ph == 5) begin
        drain();
        write_reg(CFG_FRAME_LIMIT, 7'd1);    // lowered while full
        random_refs(10, 4);
      end
      drain();
    end

    $display("Covered %0d result words: %0d hits, %0d evictions, %0d table-full,",
             n_words_out, n_hits, n_evicts, n_full);
    $display("both replacement modes, limits 0..127 and four idling patterns.");
    if (n_errors == 0 && expected_rsp.size() == 0)
      $display("** page_replacement_lru_fifo_unit: PASSED **");
    else
      $display("** page_replacement_lru_fifo_unit: FAILED **");
    $finish;
  end
endmodule

FILE: page_replacement_lru_fifo_unit.f
hw/rtl/prl_pkg.sv
hw/rtl/prl_if.sv
hw/rtl/prl_ram.sv
hw/rtl/prl_scan.sv
hw/rtl/page_replacement_lru_fifo_unit.sv
bench/prl_tb_if.sv
bench/page_replacement_lru_fifo_unit_tb.sv
